// ===== hw/rtl/fde_pkg.sv =====
// ----------------------------------------------------------------------------
// FNV-1a digest engine package
// Shared constants, command/status types and the FNV byte fold.
// ----------------------------------------------------------------------------
package fde_pkg;

    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
    localparam int unsigned MIX_SHR_A = 30;
    localparam int unsigned MIX_SHR_B = 27;
    localparam int unsigned MIX_SHR_C = 31;

    localparam logic [1:0] MODE_64  = 2'd0;
    localparam logic [1:0] MODE_128 = 2'd1;
    localparam logic [1:0] MODE_256 = 2'd2;

    // partial product phases of the 64x64 (mod 2^64) multiply
    localparam logic [1:0] MUL_PH_LL = 2'd0;
    localparam logic [1:0] MUL_PH_LH = 2'd1;
    localparam logic [1:0] MUL_PH_HL = 2'd2;

    typedef enum logic [2:0] {
        FDE_IDLE,
        FDE_MIX_LOAD,
        FDE_MIX_MUL,
        FDE_EMIT_MIX,
        FDE_EMIT_LO,
        FDE_HASH,
        FDE_EMIT_H
    } t_fde_state;

    typedef enum logic [1:0] {
        RND_HI,
        RND_LO2,
        RND_HI2
    } t_fde_round;

    typedef enum logic [1:0] {
        OSEL_LO,
        OSEL_H,
        OSEL_MIX
    } t_out_sel;

    typedef enum logic {
        SH_LO,
        SH_H
    } t_sh_src;

    typedef struct packed {
        logic       take_item;
        logic       hash_load;
        logic       h_basis;
        t_sh_src    sh_src;
        logic       hash_step;
        logic       mix_load;
        logic       mix_b;
        logic       mul_step;
        logic [1:0] mul_phase;
        logic       out_load;
        t_out_sel   out_sel;
        logic       out_last;
    } t_fde_cmd;

    typedef struct packed {
        logic out_free;
    } t_fde_stat;

    // h = (h ^ b) * 0x100000001b3 mod 2^64; prime = 2^40 + 0x1b3
    function automatic logic [63:0] fde_fold(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

// ===== hw/rtl/fde_dp.sv =====
// ----------------------------------------------------------------------------
// FNV-1a digest datapath
// Message accumulator, byte-serial word hasher, mix multiplier, output register.
// ----------------------------------------------------------------------------
module fde_dp import fde_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_fde_cmd    i_cmd,
    output t_fde_stat   o_stat,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_last_byte,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [63:0] o_digest_word,
    output logic        o_word_last
);

    logic [63:0] r_acc, n_acc;
    logic [63:0] r_lo, n_lo;
    logic [63:0] r_h, n_h;
    logic [63:0] r_sh, n_sh;
    logic [63:0] r_z, n_z;
    logic [63:0] r_prod, n_prod;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_out_word, n_out_word;
    logic        r_out_last, n_out_last;

    logic [63:0] folded;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [63:0] mix_c;
    logic [63:0] mix_out;

    assign folded  = i_byte_present ? fde_fold(r_acc, i_data_byte) : r_acc;
    assign mix_c   = i_cmd.mix_b ? MIX_MUL_B : MIX_MUL_A;
    assign mul_a   = (i_cmd.mul_phase == MUL_PH_HL) ? r_z[63:32] : r_z[31:0];
    assign mul_b   = (i_cmd.mul_phase == MUL_PH_LH) ? mix_c[63:32] : mix_c[31:0];
    assign mul_p   = 64'(mul_a) * 64'(mul_b);
    assign mix_out = r_prod ^ (r_prod >> MIX_SHR_C);

    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_acc       = r_acc;
        n_lo        = r_lo;
        n_h         = r_h;
        n_sh        = r_sh;
        n_z         = r_z;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        n_out_last  = r_out_last;

        if (i_cmd.take_item) begin
            if (i_last_byte) begin
                n_lo  = folded;
                n_acc = FNV_BASIS;
            end else begin
                n_acc = folded;
            end
        end

        if (i_cmd.hash_load) begin
            n_sh = (i_cmd.sh_src == SH_LO) ? r_lo : r_h;
            if (i_cmd.h_basis) begin
                n_h = FNV_BASIS;
            end
        end else if (i_cmd.hash_step) begin
            n_h  = fde_fold(r_h, r_sh[7:0]);
            n_sh = r_sh >> 8;
        end

        if (i_cmd.mix_load) begin
            n_z = i_cmd.mix_b ? (r_prod ^ (r_prod >> MIX_SHR_B))
                              : (r_lo ^ (r_lo >> MIX_SHR_A));
        end

        if (i_cmd.mul_step) begin
            if (i_cmd.mul_phase == MUL_PH_LL) begin
                n_prod = mul_p;
            end else begin
                n_prod = r_prod + {mul_p[31:0], 32'd0};
            end
        end

        if (i_cmd.out_load) begin
            n_out_valid = 1'b1;
            n_out_last  = i_cmd.out_last;
            case (i_cmd.out_sel)
                OSEL_LO:  n_out_word = r_lo;
                OSEL_H:   n_out_word = r_h;
                OSEL_MIX: n_out_word = mix_out;
                default:  n_out_word = r_h;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= FNV_BASIS;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
        r_lo       <= n_lo;
        r_h        <= n_h;
        r_sh       <= n_sh;
        r_z        <= n_z;
        r_prod     <= n_prod;
        r_out_word <= n_out_word;
        r_out_last <= n_out_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_digest_word = r_out_word;
    assign o_word_last   = r_out_last;

endmodule

// ===== hw/rtl/fde_ctrl.sv =====
// ----------------------------------------------------------------------------
// FNV-1a digest controller
// Sequences byte intake, the digest tail and the output loads.
// ----------------------------------------------------------------------------
module fde_ctrl import fde_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_last_byte,
    output logic       o_in_stall,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_data,
    input  t_fde_stat  i_stat,
    output t_fde_cmd   o_cmd
);

    t_fde_state r_state, n_state;
    t_fde_round r_round, n_round;
    logic [2:0] r_cnt, n_cnt;
    logic       r_mix_b, n_mix_b;
    logic [1:0] r_mode, n_mode;

    logic wide;
    logic accept;

    assign wide       = (r_mode == MODE_128) || (r_mode == MODE_256);
    assign o_in_stall = (r_state != FDE_IDLE);
    assign accept     = i_in_valid && (r_state == FDE_IDLE);
    assign n_mode     = i_cfg_we ? i_cfg_data : r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FDE_IDLE;
            r_round <= RND_HI;
            r_cnt   <= 3'd0;
            r_mix_b <= 1'b0;
            r_mode  <= MODE_64;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_cnt   <= n_cnt;
            r_mix_b <= n_mix_b;
            r_mode  <= n_mode;
        end
    end

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_cnt   = r_cnt;
        n_mix_b = r_mix_b;
        o_cmd   = '0;
        o_cmd.mix_b     = r_mix_b;
        o_cmd.mul_phase = r_cnt[1:0];

        case (r_state)
            FDE_IDLE: begin
                if (accept) begin
                    o_cmd.take_item = 1'b1;
                    if (i_last_byte) begin
                        n_mix_b = 1'b0;
                        n_state = wide ? FDE_EMIT_LO : FDE_MIX_LOAD;
                    end
                end
            end
            FDE_MIX_LOAD: begin
                o_cmd.mix_load = 1'b1;
                n_cnt   = 3'd0;
                n_state = FDE_MIX_MUL;
            end
            FDE_MIX_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt = r_cnt + 3'd1;
                if (r_cnt[1:0] == MUL_PH_HL) begin
                    if (r_mix_b) begin
                        n_state = FDE_EMIT_MIX;
                    end else begin
                        n_mix_b = 1'b1;
                        n_state = FDE_MIX_LOAD;
                    end
                end
            end
            FDE_EMIT_MIX: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_MIX;
                    o_cmd.out_last = 1'b1;
                    n_state = FDE_IDLE;
                end
            end
            FDE_EMIT_LO: begin
                // emit lo and start hashing its bytes in the same cycle
                if (i_stat.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_sel   = OSEL_LO;
                    o_cmd.hash_load = 1'b1;
                    o_cmd.h_basis   = 1'b1;
                    o_cmd.sh_src    = SH_LO;
                    n_round = RND_HI;
                    n_cnt   = 3'd0;
                    n_state = FDE_HASH;
                end
            end
            FDE_HASH: begin
                o_cmd.hash_step = 1'b1;
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    n_state = FDE_EMIT_H;
                end
            end
            FDE_EMIT_H: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_H;
                    n_cnt = 3'd0;
                    if (r_round == RND_HI2 || (r_mode == MODE_128)) begin
                        o_cmd.out_last = 1'b1;
                        n_state = FDE_IDLE;
                    end else begin
                        // second digest: lo2 folds hi into hi, hi2 folds lo2 from basis
                        o_cmd.hash_load = 1'b1;
                        o_cmd.sh_src    = SH_H;
                        o_cmd.h_basis   = (r_round == RND_LO2);
                        n_round = (r_round == RND_HI) ? RND_LO2 : RND_HI2;
                        n_state = FDE_HASH;
                    end
                end
            end
            default: begin
                n_state = FDE_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/fnv1a_digest_engine.sv =====
// Non-final item: accepted and its byte, if present, folded in; next item may follow at once.
// Final item: input stalls for the digest tail; 64-bit mode runs two 3-step 32x32
// multiply sequences, 128-bit and 256-bit modes fold each word byte by byte.
// Output words pass through one output register; downstream stall only delays the tail.
// Synchronous active-low reset: idle, accumulator = FNV basis, mode = 64-bit, no output.
// ----------------------------------------------------------------------------
// FNV-1a digest engine top level
// Byte-serial FNV-1a hash with 64/128/256-bit digest output.
// ----------------------------------------------------------------------------
module fnv1a_digest_engine import fde_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_digest_word,
    output logic        o_word_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data
);

    t_fde_cmd  cmd;
    t_fde_stat stat;

    assign o_cfg_ready = 1'b1;

    fde_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_byte (i_last_byte),
        .o_in_stall  (o_in_stall),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fde_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_last_byte    (i_last_byte),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_digest_word  (o_digest_word),
        .o_word_last    (o_word_last)
    );

endmodule

// ===== hw/rtl/fde_checker.sv =====
// ----------------------------------------------------------------------------
// FNV-1a digest engine port checker
// Port-level properties of the digest engine, bound to the top level.
// ----------------------------------------------------------------------------
module fde_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_last_byte,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_digest_word,
    input logic        o_word_last
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // hold a stalled item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_digest_word)
                                       && $stable(o_word_last))
        else $error("stalled output item changed");

    a_tail_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last_byte |=> o_in_stall)
        else $error("input not stalled during digest tail");

    a_body_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_last_byte |=> !o_in_stall)
        else $error("input stalled after a non-final item");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("engine not idle after reset");

endmodule

bind fnv1a_digest_engine fde_checker u_fde_checker (.*);

// ===== tb/sv/fde_digest_sb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FNV-1a digest engine scoreboard
// Predicts the digest words of every message from the accepted input items
// and checks the words the engine emits against them, oldest first.
// ----------------------------------------------------------------------------
package fde_digest_sb_pkg;
    import fde_pkg::*;

    localparam logic [63:0] FNV_PRIME     = 64'h00000100000001b3;
    // the undefined mode code falls back to the 64-bit finalized digest
    localparam logic [1:0]  MODE_64_ALIAS = 2'd3;

    typedef struct packed {
        logic [63:0] word;
        logic        last;
    } t_digest_word;

    class fde_digest_sb;
        logic [63:0]  acc;
        logic [1:0]   mode;
        t_digest_word awaited[$];
        int unsigned  mismatches;
        int unsigned  words_checked;
        int unsigned  messages;

        function new();
            acc           = FNV_BASIS;
            mode          = MODE_64;
            mismatches    = 0;
            words_checked = 0;
            messages      = 0;
        endfunction

        function void set_mode(logic [1:0] m);
            mode = m;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function logic [63:0] fold_byte(logic [63:0] h, logic [7:0] b);
            return (h ^ {56'd0, b}) * FNV_PRIME;
        endfunction

        // fold the eight bytes of w into h, least significant byte first
        function logic [63:0] fold_word(logic [63:0] h, logic [63:0] w);
            for (int i = 0; i < 8; i++) begin
                h = fold_byte(h, w[8*i +: 8]);
            end
            return h;
        endfunction

        function logic [63:0] splitmix(logic [63:0] z);
            z = (z ^ (z >> MIX_SHR_A)) * MIX_MUL_A;
            z = (z ^ (z >> MIX_SHR_B)) * MIX_MUL_B;
            return z ^ (z >> MIX_SHR_C);
        endfunction

        function void push_word(logic [63:0] w, logic l);
            t_digest_word e;
            e.word = w;
            e.last = l;
            awaited.push_back(e);
        endfunction

        function void note_item(logic [7:0] b, logic present, logic last);
            logic [63:0] lo;
            logic [63:0] hi;
            logic [63:0] lo2;
            if (present) begin
                acc = fold_byte(acc, b);
            end
            if (!last) begin
                return;
            end
            lo  = acc;
            acc = FNV_BASIS;
            messages++;
            case (mode)
                MODE_128, MODE_256: begin
                    hi = fold_word(FNV_BASIS, lo);
                    push_word(lo, 1'b0);
                    push_word(hi, mode == MODE_128);
                    if (mode == MODE_256) begin
                        lo2 = fold_word(fold_word(FNV_BASIS, lo), hi);
                        push_word(lo2, 1'b0);
                        push_word(fold_word(FNV_BASIS, lo2), 1'b1);
                    end
                end
                default: begin
                    push_word(splitmix(lo), 1'b1);
                end
            endcase
        endfunction

        task report(string msg);
            $display("[%0t] digest check: %s", $time, msg);
            mismatches++;
        endtask

        task check_word(logic [63:0] w, logic l);
            t_digest_word want;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected word %h last %b", w, l));
                return;
            end
            want = awaited.pop_front();
            if (w !== want.word) begin
                report($sformatf("word %0d: digest_word %h, want %h",
                                 words_checked, w, want.word));
            end
            if (l !== want.last) begin
                report($sformatf("word %0d: word_last %b, want %b",
                                 words_checked, l, want.last));
            end
            words_checked++;
        endtask
    endclass

endpackage

// ===== tb/sv/tb_fnv1a_digest_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FNV-1a digest engine testbench
// Sends directed and random byte messages in every digest mode, with random
// gaps and output stalls, and checks each emitted digest word in order.
// ----------------------------------------------------------------------------
module tb_fnv1a_digest_engine;
    import fde_pkg::*;
    import fde_digest_sb_pkg::*;

    localparam int unsigned TAIL_CYCLES  = 40;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PHASE_ITEMS  = 20;
    localparam int unsigned NUM_PHASES   = 7;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_data_byte    = 8'd0;
    logic        i_byte_present = 1'b0;
    logic        i_last_byte    = 1'b0;
    logic        i_out_stall    = 1'b0;
    logic        i_cfg_valid    = 1'b0;
    logic [1:0]  i_cfg_data     = 2'd0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [63:0] o_digest_word;
    logic        o_word_last;
    logic        o_cfg_ready;

    fde_digest_sb sb = new();

    int unsigned items_sent   = 0;
    int unsigned send_gap_max = 3;
    int unsigned recv_gap_max = 3;
    int unsigned hold_len     = 0;
    int unsigned idle_cycles  = 0;

    logic [1:0] mode_seq [NUM_PHASES] = '{MODE_64, MODE_128, MODE_256, MODE_64_ALIAS,
                                          MODE_256, MODE_128, MODE_64};
    int unsigned send_gaps [NUM_PHASES] = '{10, 0, 0, 0, 10, 10, 4};
    int unsigned recv_gaps [NUM_PHASES] = '{10, 10, 10, 0, 0, 10, 4};

    fnv1a_digest_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_byte_present (i_byte_present),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_digest_word  (o_digest_word),
        .o_word_last    (o_word_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_word(o_digest_word, o_word_last);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("fnv1a_digest_engine: mismatch");
            $finish;
        end
    end

    // receiver: stall a random number of cycles before each word, or a long
    // hold-off when one is requested
    initial begin
        int unsigned n;
        forever begin
            if (hold_len > 0) begin
                n        = hold_len;
                hold_len = 0;
            end else begin
                n = $urandom_range(0, recv_gap_max);
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    task automatic send_item(input logic [7:0] b, input logic present, input logic last);
        int unsigned gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_data_byte    <= b;
        i_byte_present <= present;
        i_last_byte    <= last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(b, present, last);
        items_sent++;
    endtask

    // random message: bytes with stray empty items, ended either on the
    // final byte or on an extra empty item
    task automatic send_message();
        int unsigned len;
        logic        end_on_byte;
        len         = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(0, 6);
        end_on_byte = (len > 0) && $urandom_range(0, 1);
        if ($urandom_range(0, 7) == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // let the digest tail run out before touching the mode register
    task automatic settle();
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_mode(m);
    endtask

    initial begin
        int unsigned phase_start;
        logic        paused;
        paused = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset mode: empty message, extreme bytes, ignored empty items
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'hC3, 1'b0, 1'b0);
        send_item(8'h62, 1'b1, 1'b1);
        settle();
        write_mode(MODE_128);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        settle();
        write_mode(MODE_256);
        send_item(8'h5A, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'h80, 1'b0, 1'b1);
        settle();
        write_mode(MODE_64_ALIAS);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h5A, 1'b1, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            write_mode(mode_seq[p]);
            send_gap_max = send_gaps[p];
            recv_gap_max = recv_gaps[p];
            // back up the output while the sender keeps offering items
            if (p == 2) begin
                hold_len = HOLD_CYCLES;
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if (p == 4 && !paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
                    drain();
                    paused = 1'b1;
                end
                send_message();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d items in %0d messages, %0d digest words checked",
                 items_sent, sb.messages, sb.words_checked);
        $display("all four mode codes, gap-free and stalled stretches, one long output hold");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("fnv1a_digest_engine: match");
        end else begin
            $display("%0d mismatches, %0d words still awaited", sb.mismatches, sb.pending());
            $display("fnv1a_digest_engine: mismatch");
        end
        $finish;
    end

endmodule
